// ----- design/crc8_packet_deframer_unit_defines.svh -----
// Assertion macros shared by the deframer checker.
`ifndef CRC8_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define CRC8_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cpd_pkg.sv -----
// Shared constants, types and the CRC-8 step function for the deframer.
`default_nettype none
package cpd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;
    localparam logic [BYTE_W-1:0] START_RST     = 8'd170;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 6'd32;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_B = BYTE_W'(MAX_PAYLOAD);

    // Register indexes (taken from paddr[2])
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_MAX_LEN    = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;      // back to hunting: clear type, length, count, crc, emit index
        logic ld_type;  // latch type byte, feed crc
        logic ld_len;   // latch length byte, feed crc, zero count
        logic pay;      // store payload byte, feed crc, bump count
        logic emit;     // load next result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic start_hit;  // input byte equals start byte
        logic len_ok;     // input byte is an acceptable length
        logic len_zero;   // input byte is zero
        logic cnt_done;   // this payload byte is the final one
        logic crc_hit;    // input byte equals the running crc
        logic emit_last;  // next result to emit closes the packet
        logic out_free;   // output register can take a result this cycle
    } t_sts;

    // One CRC-8 byte step, MSB first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/cpd_in_if.sv -----
// Receive byte channel: valid/ready with one received byte.
`default_nettype none
interface cpd_in_if import cpd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ----- design/cpd_out_if.sv -----
// Packet result channel: valid/ready with one verified payload entry.
`default_nettype none
interface cpd_out_if import cpd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pkt_type;
    logic [LEN_W-1:0]  pkt_len;
    logic [IDX_W-1:0]  payload_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              last;

    modport source (output valid, output pkt_type, output pkt_len, output payload_index,
                    output payload_byte, output payload_valid, output last, input ready);
    modport sink   (input valid, input pkt_type, input pkt_len, input payload_index,
                    input payload_byte, input payload_valid, input last, output ready);
endinterface
`default_nettype wire

// ----- design/cpd_ctrl.sv -----
// Frame parsing controller: one-hot phase machine issuing datapath commands.
`default_nettype none
module cpd_ctrl import cpd_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        ST_HUNT    = 6'b000001,
        ST_TYPE    = 6'b000010,
        ST_LEN     = 6'b000100,
        ST_PAYLOAD = 6'b001000,
        ST_CRC     = 6'b010000,
        ST_EMIT    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    // Input is held off only while a packet is being played out
    assign o_in_ready = (r_state != ST_EMIT);
    assign w_acc      = i_in_valid && o_in_ready;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_HUNT: begin
                if (w_acc && i_sts.start_hit) begin
                    o_cmd.clr = 1'b1;
                    n_state   = ST_TYPE;
                end
            end
            ST_TYPE: begin
                if (w_acc) begin
                    o_cmd.ld_type = 1'b1;
                    n_state       = ST_LEN;
                end
            end
            ST_LEN: begin
                if (w_acc) begin
                    if (!i_sts.len_ok) begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_HUNT;
                    end else begin
                        o_cmd.ld_len = 1'b1;
                        n_state      = i_sts.len_zero ? ST_CRC : ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (w_acc) begin
                    o_cmd.pay = 1'b1;
                    if (i_sts.cnt_done) begin
                        n_state = ST_CRC;
                    end
                end
            end
            ST_CRC: begin
                if (w_acc) begin
                    if (i_sts.crc_hit) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_HUNT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_HUNT;
                    end
                end
            end
            default: begin
                o_cmd.clr = 1'b1;
                n_state   = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- design/cpd_datapath.sv -----
// Deframer datapath: frame fields, running CRC, payload memory, output register.
`default_nettype none
module cpd_datapath import cpd_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  t_cmd        i_cmd,
    output t_sts              o_sts,
    input  wire  [BYTE_W-1:0] i_in_byte,
    input  wire  [BYTE_W-1:0] i_start_byte,
    input  wire  [LEN_W-1:0]  i_max_len,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_pkt_type,
    output logic [LEN_W-1:0]  o_pkt_len,
    output logic [IDX_W-1:0]  o_payload_index,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_payload_valid,
    output logic              o_last
);

    logic [BYTE_W-1:0] r_type;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_crc;
    logic [LEN_W-1:0]  r_eidx;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    logic              r_ov;
    logic [BYTE_W-1:0] r_o_type;
    logic [LEN_W-1:0]  r_o_len;
    logic [IDX_W-1:0]  r_o_idx;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_pv;
    logic              r_o_last;

    logic [BYTE_W-1:0] w_crc_next;
    logic [LEN_W-1:0]  w_cnt_inc;
    logic [LEN_W-1:0]  w_eidx_inc;
    logic              w_feed;

    assign w_crc_next = crc8_feed(r_crc, i_in_byte);
    assign w_cnt_inc  = r_cnt + LEN_W'(1);
    assign w_eidx_inc = r_eidx + LEN_W'(1);
    assign w_feed     = i_cmd.ld_type || i_cmd.ld_len || i_cmd.pay;

    // Status toward the controller
    always_comb begin
        o_sts.start_hit = (i_in_byte == i_start_byte);
        o_sts.len_ok    = (i_in_byte <= {{(BYTE_W-LEN_W){1'b0}}, i_max_len})
                          && (i_in_byte <= MAX_PAYLOAD_B);
        o_sts.len_zero  = (i_in_byte == '0);
        o_sts.cnt_done  = (w_cnt_inc >= r_len);
        o_sts.crc_hit   = (i_in_byte == r_crc);
        o_sts.emit_last = (r_len == '0) || (w_eidx_inc == r_len);
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    // Frame fields, byte count and running crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= '0;
            r_len  <= '0;
            r_cnt  <= '0;
            r_crc  <= '0;
            r_eidx <= '0;
        end else if (i_cmd.clr) begin
            r_type <= '0;
            r_len  <= '0;
            r_cnt  <= '0;
            r_crc  <= '0;
            r_eidx <= '0;
        end else begin
            if (w_feed) begin
                r_crc <= w_crc_next;
            end
            if (i_cmd.ld_type) begin
                r_type <= i_in_byte;
            end
            if (i_cmd.ld_len) begin
                r_len <= i_in_byte[LEN_W-1:0];
                r_cnt <= '0;
            end
            if (i_cmd.pay) begin
                r_cnt <= w_cnt_inc;
            end
            if (i_cmd.emit) begin
                r_eidx <= w_eidx_inc;
            end
        end
    end

    // Payload memory: one write port, registered read into the output slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay) begin
            r_mem[r_cnt[IDX_W-1:0]] <= i_in_byte;
        end
        if (i_cmd.emit) begin
            r_o_byte <= r_mem[r_eidx[IDX_W-1:0]];
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_type <= r_type;
            r_o_len  <= r_len;
            r_o_idx  <= r_eidx[IDX_W-1:0];
            r_o_pv   <= (r_len != '0);
            r_o_last <= o_sts.emit_last;
        end
    end

    // Output valid: set on load, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_pkt_type      = r_o_type;
    assign o_pkt_len       = r_o_len;
    assign o_payload_index = r_o_idx;
    assign o_payload_byte  = r_o_pv ? r_o_byte : '0;
    assign o_payload_valid = r_o_pv;
    assign o_last          = r_o_last;

endmodule
`default_nettype wire

// ----- design/crc8_packet_deframer_unit.sv -----
// Usage:
//   i_rx takes one received byte per request (valid/ready). The block hunts for
//   start_byte, then reads type, length, length payload bytes and a CRC-8 byte
//   (poly 0x07, init 0) over type, length and payload.
//   o_pkt delivers a verified packet as one request per payload byte in index
//   order with last on the final one; an empty packet gives one request with
//   payload_valid low. A bad CRC or an oversize length delivers nothing.
//   Throughput: one byte per cycle while a frame is parsed. After a matching
//   CRC byte, i_rx.ready drops while the result sequencer reads the payload
//   memory, one entry per cycle while the receiver keeps taking results.
//   The first result is registered when the emit phase finds the output free.
//   Receiver stall: the output register holds its result and the sequencer
//   waits; i_rx stays not ready until the last result is loaded.
//   Reset (synchronous, active low): back to hunting, registers to defaults
//   (start_byte 170, max_length 32), output empty. No memory clearing needed.
//   Config: APB writes at 0 (start_byte) and 4 (max_length), only while idle.
`default_nettype none
module crc8_packet_deframer_unit import cpd_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    cpd_in_if.sink             i_rx,
    cpd_out_if.source          o_pkt,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [APB_AW-1:0]  paddr,
    input  wire  [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [LEN_W-1:0]  r_max_len;
    logic              w_wr;
    t_cmd              w_cmd;
    t_sts              w_sts;

    // Register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_START_BYTE: r_start_byte <= pwdata[BYTE_W-1:0];
                REG_MAX_LEN:    r_max_len    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux; low address bits are ignored
    always_comb begin
        unique case (paddr[2])
            REG_START_BYTE: prdata = {{(APB_DW-BYTE_W){1'b0}}, r_start_byte};
            REG_MAX_LEN:    prdata = {{(APB_DW-LEN_W){1'b0}}, r_max_len};
            default:        prdata = '0;
        endcase
    end

    cpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_rx.ready),
        .o_cmd      (w_cmd)
    );

    cpd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_in_byte       (i_rx.in_byte),
        .i_start_byte    (r_start_byte),
        .i_max_len       (r_max_len),
        .i_out_ready     (o_pkt.ready),
        .o_out_valid     (o_pkt.valid),
        .o_pkt_type      (o_pkt.pkt_type),
        .o_pkt_len       (o_pkt.pkt_len),
        .o_payload_index (o_pkt.payload_index),
        .o_payload_byte  (o_pkt.payload_byte),
        .o_payload_valid (o_pkt.payload_valid),
        .o_last          (o_pkt.last)
    );

endmodule
`default_nettype wire

// ----- design/cpd_checker.sv -----
// Port-level checker for the deframer, bound to the top level.
`default_nettype none
`include "crc8_packet_deframer_unit_defines.svh"
module cpd_checker import cpd_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [BYTE_W-1:0] i_pkt_type,
    input wire [LEN_W-1:0]  i_pkt_len,
    input wire [IDX_W-1:0]  i_payload_index,
    input wire [BYTE_W-1:0] i_payload_byte,
    input wire              i_payload_valid,
    input wire              i_last
);

    // A stalled result keeps its contents
    `CPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pkt_type) && $stable(i_pkt_len) && $stable(i_payload_index) && $stable(i_payload_byte) && $stable(i_last), "stalled result changed")

    // Empty packet: single closing result with zero fields
    `CPD_ASSERT_NOW(a_empty_pkt, i_clk, i_rst_n, i_out_valid && !i_payload_valid, i_last && (i_pkt_len == '0) && (i_payload_byte == '0) && (i_payload_index == '0), "bad empty packet result")

    // last marks exactly the final payload index
    `CPD_ASSERT_NOW(a_last_idx, i_clk, i_rst_n, i_out_valid && i_payload_valid, (i_pkt_len != '0) && (i_last == ({1'b0, i_payload_index} + LEN_W'(1) == i_pkt_len)), "last and index disagree")

    // Inside a packet the next result follows at once
    `CPD_ASSERT_NEXT(a_burst, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last, i_out_valid && (i_payload_index == $past(i_payload_index) + IDX_W'(1)), "gap or skip inside packet")

endmodule

bind crc8_packet_deframer_unit cpd_checker u_cpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_pkt.valid),
    .i_out_ready     (o_pkt.ready),
    .i_pkt_type      (o_pkt.pkt_type),
    .i_pkt_len       (o_pkt.pkt_len),
    .i_payload_index (o_pkt.payload_index),
    .i_payload_byte  (o_pkt.payload_byte),
    .i_payload_valid (o_pkt.payload_valid),
    .i_last          (o_pkt.last)
);
`default_nettype wire

// ----- tb/crc8_packet_deframer_unit_test.sv -----
// Self-checking testbench for the CRC-8 packet deframer: random framed byte streams, APB setup.
`timescale 1ns / 100ps

module crc8_packet_deframer_unit_test;
    import cpd_pkg::*;

    localparam int RUN_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_QUOTA = 55;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_CRC
    } t_rx_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] pkt_type;
        logic [LEN_W-1:0]  pkt_len;
        logic [IDX_W-1:0]  payload_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              last;
    } t_pkt_entry;

    // CRC-8, poly x^8+x^2+x+1, MSB first
    function automatic t_byte crc8_next(input t_byte crc, input t_byte b);
        t_byte r;
        r = crc ^ b;
        repeat (BYTE_W) r = {r[BYTE_W-2:0], 1'b0} ^ (r[BYTE_W-1] ? 8'h07 : 8'h00);
        return r;
    endfunction

    // Frame parser model plus the queue of packet entries still owed by the block
    class packet_scoreboard;
        t_byte             start_byte;
        logic [LEN_W-1:0]  max_len;
        t_rx_phase         phase;
        t_byte             frame_type;
        logic [LEN_W-1:0]  frame_len;
        logic [LEN_W-1:0]  rx_count;
        t_byte             crc;
        t_byte             payload_mem[MAX_PAYLOAD];
        t_pkt_entry        pending_entries[$];
        int                fail_count;

        function new();
            start_byte = 8'd170;
            max_len    = 6'd32;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_HUNT;
            frame_type = '0;
            frame_len  = '0;
            rx_count   = '0;
            crc        = '0;
        endfunction

        function void write_reg(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_START_BYTE) begin
                start_byte = value[BYTE_W-1:0];
            end else begin
                max_len = value[LEN_W-1:0];
            end
        endfunction

        function logic [APB_DW-1:0] reg_value(logic idx);
            if (idx == REG_START_BYTE) return APB_DW'(start_byte);
            return APB_DW'(max_len);
        endfunction

        function int eff_max_len();
            return (max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(max_len);
        endfunction

        // Advance the parser by one accepted byte and queue any packet entries
        function void note_rx_byte(t_byte b);
            t_pkt_entry e;
            case (phase)
                PH_HUNT: begin
                    if (b == start_byte) begin
                        restart();
                        phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    frame_type = b;
                    crc = crc8_next(crc, b);
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    // full 8-bit compare; oversize drops the frame silently
                    if (b > max_len || b > MAX_PAYLOAD) begin
                        restart();
                    end else begin
                        frame_len = b[LEN_W-1:0];
                        crc = crc8_next(crc, b);
                        rx_count = '0;
                        phase = (b == 0) ? PH_CRC : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    payload_mem[rx_count] = b;
                    crc = crc8_next(crc, b);
                    rx_count = rx_count + 1'b1;
                    if (rx_count >= frame_len) phase = PH_CRC;
                end
                PH_CRC: begin
                    if (crc == b) begin
                        if (frame_len == 0) begin
                            e = '{frame_type, '0, '0, '0, 1'b0, 1'b1};
                            pending_entries.push_back(e);
                        end else begin
                            for (int i = 0; i < frame_len; i++) begin
                                e.pkt_type      = frame_type;
                                e.pkt_len       = frame_len;
                                e.payload_index = IDX_W'(i);
                                e.payload_byte  = payload_mem[i];
                                e.payload_valid = 1'b1;
                                e.last          = (i + 1 == frame_len);
                                pending_entries.push_back(e);
                            end
                        end
                    end
                    restart();
                end
                default: restart();
            endcase
        endfunction

        function void cmp_field(string field, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
                fail_count++;
            end
        endfunction

        function void check_pkt_entry(t_pkt_entry act);
            t_pkt_entry want;
            if (pending_entries.size() == 0) begin
                $error("unexpected packet entry: type 0x%0h index %0d",
                       act.pkt_type, act.payload_index);
                fail_count++;
                return;
            end
            want = pending_entries.pop_front();
            cmp_field("pkt_type", want.pkt_type, act.pkt_type);
            cmp_field("pkt_len", want.pkt_len, act.pkt_len);
            cmp_field("payload_index", want.payload_index, act.payload_index);
            cmp_field("payload_byte", want.payload_byte, act.payload_byte);
            cmp_field("payload_valid", want.payload_valid, act.payload_valid);
            cmp_field("last", want.last, act.last);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cpd_in_if  rx_if();
    cpd_out_if pkt_if();

    crc8_packet_deframer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_pkt   (pkt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    packet_scoreboard sb;
    int    tx_max_gap;
    int    pkt_max_stall;
    int    cycle_count;
    t_byte tx_q[$];
    t_byte body_q[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stall before each request, then check on acceptance
    initial begin : pkt_sink
        int stall;
        pkt_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, pkt_max_stall);
            if (stall > 0) begin
                pkt_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pkt_if.ready <= 1'b1;
            do @(posedge i_clk); while (pkt_if.valid !== 1'b1);
            sb.check_pkt_entry('{pkt_if.pkt_type, pkt_if.pkt_len, pkt_if.payload_index,
                                 pkt_if.payload_byte, pkt_if.payload_valid, pkt_if.last});
        end
    end

    // One byte request; valid stays high across back-to-back bytes
    task automatic send_byte(input t_byte b);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.in_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        sb.note_rx_byte(b);
    endtask

    task automatic send_all();
        foreach (tx_q[i]) send_byte(tx_q[i]);
        tx_q.delete();
    endtask

    // Queue start, type, length, body_q and CRC (optionally corrupted)
    task automatic add_frame(input t_byte ptype, input t_byte len_byte, input t_byte crc_xor);
        t_byte c;
        c = crc8_next(8'h00, ptype);
        c = crc8_next(c, len_byte);
        tx_q.push_back(sb.start_byte);
        tx_q.push_back(ptype);
        tx_q.push_back(len_byte);
        foreach (body_q[i]) begin
            tx_q.push_back(body_q[i]);
            c = crc8_next(c, body_q[i]);
        end
        tx_q.push_back(c ^ crc_xor);
    endtask

    // Data bytes collide with the start byte now and then
    function automatic t_byte pick_data();
        if ($urandom_range(0, 7) == 0) return sb.start_byte;
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Feed random bytes until the parser is back to hunting
    task automatic finish_open_frame();
        while (sb.phase != PH_HUNT) send_byte(t_byte'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_entries.size() > 0);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then read back
    task automatic reg_write(input logic idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== sb.reg_value(idx)) begin
            $error("register %0d readback: expected 0x%0h, got 0x%0h",
                   idx, sb.reg_value(idx), prdata);
            sb.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly good frames, with bad CRCs, oversize lengths, cut frames and line noise
    task automatic random_frames(input int quota);
        int    sent;
        int    kind;
        int    eff;
        int    len;
        t_byte b;
        sent = 0;
        while (sent < quota) begin
            finish_open_frame();
            eff = sb.eff_max_len();
            len = ($urandom_range(0, 9) == 0) ? eff : $urandom_range(0, (eff < 6) ? eff : 6);
            body_q.delete();
            repeat (len) body_q.push_back(pick_data());
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                add_frame(pick_data(), t_byte'(len), 8'h00);
            end else if (kind < 77) begin
                add_frame(pick_data(), t_byte'(len), t_byte'($urandom_range(1, 255)));
            end else if (kind < 85) begin
                tx_q.push_back(sb.start_byte);
                tx_q.push_back(pick_data());
                tx_q.push_back(($urandom_range(0, 1) == 0) ? t_byte'(eff + 1)
                               : t_byte'($urandom_range(eff + 1, 255)));
            end else if (kind < 93) begin
                // cut short; the next frame's bytes land mid-frame
                tx_q.push_back(sb.start_byte);
                tx_q.push_back(pick_data());
                if (len > 0) begin
                    tx_q.push_back(t_byte'(len));
                    repeat ($urandom_range(0, len - 1)) tx_q.push_back(pick_data());
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    b = t_byte'($urandom_range(0, 255));
                    if (b == sb.start_byte) b = b ^ 8'h01;
                    tx_q.push_back(b);
                end
            end
            if (kind < 93) sent += tx_q.size();
            send_all();
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
    endtask

    initial begin : main
        logic [APB_DW-1:0] sb_val;
        logic [APB_DW-1:0] ml_val;
        sb = new();
        tx_max_gap    = 4;
        pkt_max_stall = 4;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.in_byte <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at reset settings
        tx_q.push_back(8'h00);                          // noise while hunting
        body_q.delete();
        add_frame(8'hFF, 8'd0, 8'h00);                  // empty packet
        body_q.delete();
        body_q.push_back(8'hFF);
        add_frame(8'h00, 8'd1, 8'h00);                  // one payload byte
        body_q.delete();
        body_q.push_back(8'h34);
        add_frame(8'h12, 8'd1, 8'h5A);                  // CRC mismatch
        tx_q.push_back(sb.start_byte);                  // length just over the cap
        tx_q.push_back(8'h01);
        tx_q.push_back(8'd33);
        tx_q.push_back(sb.start_byte);                  // length 0xFF
        tx_q.push_back(8'h01);
        tx_q.push_back(8'hFF);
        body_q.delete();
        add_frame(sb.start_byte, 8'd0, 8'h00);          // start byte as type
        body_q.delete();
        body_q.push_back(sb.start_byte);
        add_frame(8'h55, 8'd1, 8'h00);                  // start byte as payload
        send_all();
        settle();

        // Random phases over register settings and idle patterns
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin sb_val = 32'h00; ml_val = 32'd0; end
                1: begin sb_val = 32'hFF; ml_val = 32'd63; end
                2: begin sb_val = $urandom_range(0, 255); ml_val = $urandom_range(0, 63); end
                3: begin sb_val = 32'd170; ml_val = 32'd32; end
                4: begin sb_val = $urandom_range(0, 255); ml_val = $urandom_range(1, 8); end
                default: begin sb_val = $urandom_range(0, 255); ml_val = 32'd32; end
            endcase
            case (p % 4)
                0: begin tx_max_gap = 4; pkt_max_stall = 4; end
                1: begin tx_max_gap = 0; pkt_max_stall = 0; end
                2: begin tx_max_gap = 4; pkt_max_stall = 0; end
                default: begin tx_max_gap = 0; pkt_max_stall = 4; end
            endcase
            reg_write(REG_START_BYTE, sb_val);
            reg_write(REG_MAX_LEN, ml_val);
            random_frames(PHASE_QUOTA);
            finish_open_frame();
            settle();
        end

        if (sb.fail_count == 0 && sb.pending_entries.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/cpd_pkg.sv
design/cpd_in_if.sv
design/cpd_out_if.sv
design/cpd_ctrl.sv
design/cpd_datapath.sv
design/crc8_packet_deframer_unit.sv
design/cpd_checker.sv
tb/crc8_packet_deframer_unit_test.sv
